>>> hdl/literal_type_classifier_defines.svh
// ----------------------------------------------------------------------------
// literal_type_classifier_defines: shared assertion macros
// Each macro expects signals named clk and arst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef LITERAL_TYPE_CLASSIFIER_DEFINES_SVH
`define LITERAL_TYPE_CLASSIFIER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define LTC_ASSERT_NOW(name, trig, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define LTC_ASSERT_NEXT(name, trig, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

>>> hdl/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg: literal classifier shared definitions
// State codes, class codes and the step record passed from the core to the
// top level.
// ----------------------------------------------------------------------------
package ltc_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned StateW = 5;
	localparam int unsigned ClassW = 3;

	localparam logic [StateW-1:0] ST_START    = 5'd0;
	localparam logic [StateW-1:0] ST_NIL0     = 5'd1;
	localparam logic [StateW-1:0] ST_NIL1     = 5'd2;
	localparam logic [StateW-1:0] ST_NIL2     = 5'd3;
	localparam logic [StateW-1:0] ST_TRUE0    = 5'd4;
	localparam logic [StateW-1:0] ST_TRUE1    = 5'd5;
	localparam logic [StateW-1:0] ST_TRUE2    = 5'd6;
	localparam logic [StateW-1:0] ST_TRUE3    = 5'd7;
	localparam logic [StateW-1:0] ST_FALSE0   = 5'd8;
	localparam logic [StateW-1:0] ST_FALSE1   = 5'd9;
	localparam logic [StateW-1:0] ST_FALSE2   = 5'd10;
	localparam logic [StateW-1:0] ST_FALSE3   = 5'd11;
	localparam logic [StateW-1:0] ST_FALSE4   = 5'd12;
	localparam logic [StateW-1:0] ST_CH_BODY  = 5'd13;
	localparam logic [StateW-1:0] ST_CH_ESC   = 5'd14;
	localparam logic [StateW-1:0] ST_CH_END   = 5'd15;
	localparam logic [StateW-1:0] ST_CH_CLOSE = 5'd16;
	localparam logic [StateW-1:0] ST_INT      = 5'd17;
	localparam logic [StateW-1:0] ST_REAL     = 5'd18;
	localparam logic [StateW-1:0] ST_RX_OPT   = 5'd19;
	localparam logic [StateW-1:0] ST_RX_DIG   = 5'd20;
	localparam logic [StateW-1:0] ST_RX       = 5'd21;
	localparam logic [StateW-1:0] ST_DX_OPT   = 5'd22;
	localparam logic [StateW-1:0] ST_DX_DIG   = 5'd23;
	localparam logic [StateW-1:0] ST_DX       = 5'd24;
	localparam logic [StateW-1:0] ST_STR_BODY = 5'd25;
	localparam logic [StateW-1:0] ST_STR_ESC  = 5'd26;
	localparam logic [StateW-1:0] ST_STR_END  = 5'd27;
	localparam logic [StateW-1:0] ST_DRAIN    = 5'd28;

	localparam logic [ClassW-1:0] CLS_ERROR  = 3'd0;
	localparam logic [ClassW-1:0] CLS_NULL   = 3'd1;
	localparam logic [ClassW-1:0] CLS_BOOL   = 3'd2;
	localparam logic [ClassW-1:0] CLS_INT    = 3'd3;
	localparam logic [ClassW-1:0] CLS_REAL   = 3'd4;
	localparam logic [ClassW-1:0] CLS_DOUBLE = 3'd5;
	localparam logic [ClassW-1:0] CLS_CHAR   = 3'd6;
	localparam logic [ClassW-1:0] CLS_STRING = 3'd7;

	// Status of the word held in the core's compute stage.
	typedef struct packed {
		logic              busy;
		logic              emit;
		logic [ClassW-1:0] cls;
	} step_t;

endpackage

>>> hdl/ltc_core.sv
// ----------------------------------------------------------------------------
// ltc_core: scan state store and transition logic
// Holds the automaton state in a one-entry synchronous memory, reads it as a
// word is taken, and writes the next state back when the word completes.
// ----------------------------------------------------------------------------
`include "literal_type_classifier_defines.svh"

module ltc_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [ltc_pkg::ByteW-1:0]   byte_in,
	input  logic                        pop,
	output ltc_pkg::step_t              step
);
	import ltc_pkg::*;

	typedef struct packed {
		logic              term;
		logic [ClassW-1:0] cls;
		logic [StateW-1:0] nxt;
	} adv_t;

	function automatic logic is_let(input logic [ByteW-1:0] c, input logic [ByteW-1:0] low);
		return (c | 8'h20) == low;
	endfunction

	function automatic logic is_dig(input logic [ByteW-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// One automaton transition; term marks a decided literal.
	function automatic adv_t advance(input logic [StateW-1:0] s, input logic [ByteW-1:0] c);
		adv_t r;
		logic prt;
		logic zero;
		logic sgn;
		r    = '{term: 1'b1, cls: CLS_ERROR, nxt: ST_START};
		prt  = (c >= 8'd32) && (c < 8'd127);
		zero = (c == 8'd0);
		sgn  = (c == 8'h2b) || (c == 8'h2d);
		unique case (s)
			ST_START: begin
				if (is_let(c, 8'h6e)) r = '{1'b0, CLS_ERROR, ST_NIL0};
				else if (is_let(c, 8'h74)) r = '{1'b0, CLS_ERROR, ST_TRUE0};
				else if (is_let(c, 8'h66)) r = '{1'b0, CLS_ERROR, ST_FALSE0};
				else if (is_dig(c) || sgn) r = '{1'b0, CLS_ERROR, ST_INT};
				else if (c == 8'h27) r = '{1'b0, CLS_ERROR, ST_CH_BODY};
				else if (c == 8'h22) r = '{1'b0, CLS_ERROR, ST_STR_BODY};
			end
			ST_NIL0:   if (is_let(c, 8'h69)) r = '{1'b0, CLS_ERROR, ST_NIL1};
			ST_NIL1:   if (is_let(c, 8'h6c)) r = '{1'b0, CLS_ERROR, ST_NIL2};
			ST_NIL2:   if (zero) r.cls = CLS_NULL;
			ST_TRUE0:  if (is_let(c, 8'h72)) r = '{1'b0, CLS_ERROR, ST_TRUE1};
			ST_TRUE1:  if (is_let(c, 8'h75)) r = '{1'b0, CLS_ERROR, ST_TRUE2};
			ST_TRUE2:  if (is_let(c, 8'h65)) r = '{1'b0, CLS_ERROR, ST_TRUE3};
			ST_TRUE3:  if (zero) r.cls = CLS_BOOL;
			ST_FALSE0: if (is_let(c, 8'h61)) r = '{1'b0, CLS_ERROR, ST_FALSE1};
			ST_FALSE1: if (is_let(c, 8'h6c)) r = '{1'b0, CLS_ERROR, ST_FALSE2};
			ST_FALSE2: if (is_let(c, 8'h73)) r = '{1'b0, CLS_ERROR, ST_FALSE3};
			ST_FALSE3: if (is_let(c, 8'h65)) r = '{1'b0, CLS_ERROR, ST_FALSE4};
			ST_FALSE4: if (zero) r.cls = CLS_BOOL;
			ST_CH_BODY: begin
				if (prt && c == 8'h5c) r = '{1'b0, CLS_ERROR, ST_CH_ESC};
				else if (prt && c != 8'h27) r = '{1'b0, CLS_ERROR, ST_CH_END};
			end
			ST_CH_ESC:   if (prt) r = '{1'b0, CLS_ERROR, ST_CH_END};
			ST_CH_END:   if (c == 8'h27) r = '{1'b0, CLS_ERROR, ST_CH_CLOSE};
			ST_CH_CLOSE: if (zero) r.cls = CLS_CHAR;
			ST_INT, ST_REAL: begin
				if (zero) r.cls = (s == ST_INT) ? CLS_INT : CLS_REAL;
				else if (is_dig(c)) r = '{1'b0, CLS_ERROR, s};
				else if (s == ST_INT && c == 8'h2e) r = '{1'b0, CLS_ERROR, ST_REAL};
				else if (is_let(c, 8'h65)) r = '{1'b0, CLS_ERROR, ST_RX_OPT};
				else if (is_let(c, 8'h64)) r = '{1'b0, CLS_ERROR, ST_DX_OPT};
			end
			ST_RX_OPT: begin
				if (zero) r.cls = CLS_REAL;
				else if (sgn) r = '{1'b0, CLS_ERROR, ST_RX_DIG};
				else if (is_dig(c)) r = '{1'b0, CLS_ERROR, ST_RX};
			end
			ST_RX_DIG: if (is_dig(c)) r = '{1'b0, CLS_ERROR, ST_RX};
			ST_RX: begin
				if (zero) r.cls = CLS_REAL;
				else if (is_dig(c)) r = '{1'b0, CLS_ERROR, ST_RX};
			end
			ST_DX_OPT: begin
				if (zero) r.cls = CLS_DOUBLE;
				else if (sgn) r = '{1'b0, CLS_ERROR, ST_DX_DIG};
				else if (is_dig(c)) r = '{1'b0, CLS_ERROR, ST_DX};
			end
			ST_DX_DIG: if (is_dig(c)) r = '{1'b0, CLS_ERROR, ST_DX};
			ST_DX: begin
				if (zero) r.cls = CLS_DOUBLE;
				else if (is_dig(c)) r = '{1'b0, CLS_ERROR, ST_DX};
			end
			ST_STR_BODY: begin
				if (prt && c == 8'h5c) r = '{1'b0, CLS_ERROR, ST_STR_ESC};
				else if (prt && c == 8'h22) r = '{1'b0, CLS_ERROR, ST_STR_END};
				else if (prt) r = '{1'b0, CLS_ERROR, ST_STR_BODY};
			end
			ST_STR_ESC: if (prt) r = '{1'b0, CLS_ERROR, ST_STR_BODY};
			ST_STR_END: if (zero) r.cls = CLS_STRING;
			default: r = '{1'b1, CLS_ERROR, ST_START};
		endcase
		return r;
	endfunction

	logic [StateW-1:0] state_mem [1];
	logic              mem_vld_q;
	logic              busy_s1;
	logic [ByteW-1:0]  byte_s1;
	logic [StateW-1:0] cur_s1;
	adv_t              adv;
	logic              emit;
	logic [StateW-1:0] nxt_state;

	always_comb begin
		adv = advance(cur_s1, byte_s1);
		if (cur_s1 >= ST_DRAIN) begin
			// Drain and unused codes drop everything up to the zero byte.
			emit      = 1'b0;
			nxt_state = (byte_s1 == 8'd0) ? ST_START : ST_DRAIN;
		end else if (adv.term) begin
			emit      = 1'b1;
			nxt_state = (byte_s1 == 8'd0) ? ST_START : ST_DRAIN;
		end else begin
			emit      = 1'b0;
			nxt_state = adv.nxt;
		end
	end

	assign step = '{busy: busy_s1, emit: emit, cls: adv.cls};

	always_ff @(posedge clk) begin
		if (pop) begin
			state_mem[0] <= nxt_state;
		end
	end

	// A write in the same cycle as the read is forwarded into the read data.
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= byte_in;
			if (pop) cur_s1 <= nxt_state;
			else if (mem_vld_q) cur_s1 <= state_mem[0];
			else cur_s1 <= ST_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q <= 1'b0;
			busy_s1   <= 1'b0;
		end else begin
			if (pop) mem_vld_q <= 1'b1;
			if (take) busy_s1 <= 1'b1;
			else if (pop) busy_s1 <= 1'b0;
		end
	end

	`LTC_ASSERT_NOW(a_state_code, busy_s1, cur_s1 <= ST_DRAIN,
		"state read outside the valid codes")
	`LTC_ASSERT_NOW(a_class_on_zero, busy_s1 && emit && adv.cls != CLS_ERROR,
		byte_s1 == 8'd0, "class given on a nonzero byte")
	`LTC_ASSERT_NOW(a_zero_restarts, pop && byte_s1 == 8'd0, nxt_state == ST_START,
		"zero byte did not restart the scan")

endmodule

>>> hdl/literal_type_classifier.sv
// ----------------------------------------------------------------------------
// literal_type_classifier: literal kind recognizer
// Scans a zero-terminated literal one byte at a time and reports its class.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+-------------------------
//   in      | in_valid / in_stall | text_byte[7:0]
//   out     | out_valid/out_stall | literal_class[2:0]
//
// One byte per cycle is sustained unless a stalled output holds a result;
// each byte passes the compute stage, where the state read from the one-entry
// state memory is advanced and written back; any result is then registered in
// the output register. Reset returns the scan to the start state. A stalled
// output holds back only a byte that would produce a result.
// ----------------------------------------------------------------------------
`include "literal_type_classifier_defines.svh"

module literal_type_classifier (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ltc_pkg::ByteW-1:0]    text_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ltc_pkg::ClassW-1:0]   literal_class
);
	import ltc_pkg::*;

	step_t             step;
	logic              take;
	logic              pop;
	logic              out_free;
	logic              out_valid_q;
	logic [ClassW-1:0] class_q;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = step.busy && (!step.emit || out_free);
	assign in_stall = step.busy && !pop;
	assign take     = in_valid && !in_stall;

	ltc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.byte_in (text_byte),
		.pop     (pop),
		.step    (step)
	);

	always_ff @(posedge clk) begin
		if (pop && step.emit) begin
			class_q <= step.cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && step.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign literal_class = class_q;

	`LTC_ASSERT_NEXT(a_emit_shows, pop && step.emit, out_valid_q, "result word not presented")
	`LTC_ASSERT_NEXT(a_out_hold, out_valid_q && out_stall,
		out_valid_q && $stable(class_q), "stalled result word changed")
	`LTC_ASSERT_NOW(a_stall_cause, in_stall,
		step.emit && out_valid_q && out_stall, "input stalled without a waiting result")

endmodule
